>>> hdl/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg
// Shared codes, widths and defaults of the array linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alle_pkg;

  // Default node store depth
  localparam int NODE_COUNT_DEF = 16;

  // Beat layout
  localparam int OPCODE_W    = 3;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 72;   // 3 + 32 + 32 = 67, padded to bytes
  localparam int OUT_TDATA_W = 8;    // 3 + 1 + 1 = 5, padded to bytes

  // Operations
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND_TAIL = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT_AFT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_TAIL = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_AFT  = 3'd5;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONEXT = 3'd4;

endpackage

`default_nettype wire

>>> hdl/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Singly linked list kept in a fixed node store, with a free list chained
// through the same link memory. One operation per input beat, one status
// beat out.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents (low bit first)
//  in_*      in    opcode[2:0], value[34:3], key[66:35], zero pad to 72
//  out_*     out   status[2:0], list_empty[3], list_full[4], zero pad to 8
//
//  One operation at a time. Push and pop do not walk the list; append,
//  remove tail and the key operations walk the list one node per cycle
//  through the store read port, visiting at most NODE_COUNT nodes.
//  Reset (rst_n low, synchronous) empties the list and chains all nodes free.
//  A held result stalls only the next finishing operation, not the accept.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_engine #(
  parameter int NODE_COUNT = alle_pkg::NODE_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [alle_pkg::IN_TDATA_W-1:0]  in_tdata,   // opcode, value, key
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [alle_pkg::OUT_TDATA_W-1:0] out_tdata   // status, list_empty, list_full
);
  import alle_pkg::*;

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int LINK_W = $clog2(NODE_COUNT + 1);
  localparam logic [LINK_W-1:0] NIL       = LINK_W'(NODE_COUNT);
  localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(NODE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TAKE, S_POP, S_WALK, S_NEXT, S_FREE, S_LINK, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [OPCODE_W-1:0]    op_r, op_nxt;
  logic [DATA_W-1:0]      val_r, val_nxt;
  logic [DATA_W-1:0]      key_r, key_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [LINK_W-1:0]      head_r, head_nxt;
  logic [LINK_W-1:0]      free_r, free_nxt;
  logic [LINK_W-1:0]      cur_r, cur_nxt;
  logic [LINK_W-1:0]      prev_r, prev_nxt;
  logic [LINK_W-1:0]      aux_r, aux_nxt;
  logic [LINK_W-1:0]      nxt_r, nxt_nxt;
  logic [LINK_W-1:0]      steps_r, steps_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [OPCODE_W-1:0]    in_opcode;
  logic [DATA_W-1:0]      in_value;
  logic [DATA_W-1:0]      in_key;

  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_val_en;
  logic [IDX_W-1:0]       wr_val_addr;
  logic                   wr_link_en;
  logic [IDX_W-1:0]       wr_link_addr;
  logic [LINK_W-1:0]      wr_link_data;
  logic [DATA_W-1:0]      rd_value;
  logic [LINK_W-1:0]      rd_link;

  logic                   head_nil;
  logic                   free_nil;
  logic [LINK_W-1:0]      rd_link_n;
  logic                   walk_last;
  logic                   key_hit;

  function automatic logic [IDX_W-1:0] idx(input logic [LINK_W-1:0] l);
    return l[IDX_W-1:0];
  endfunction

  assign in_opcode = in_tdata[OPCODE_W-1:0];
  assign in_value  = in_tdata[OPCODE_W +: DATA_W];
  assign in_key    = in_tdata[OPCODE_W + DATA_W +: DATA_W];

  assign head_nil  = (head_r >= NIL);
  assign free_nil  = (free_r >= NIL);
  assign rd_link_n = (rd_link >= NIL) ? NIL : rd_link;
  assign walk_last = (rd_link_n == NIL) || (steps_r == LAST_STEP);
  assign key_hit   = (rd_value == key_r);

  alle_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_addr      (rd_addr),
    .wr_val_en    (wr_val_en),
    .wr_val_addr  (wr_val_addr),
    .wr_val_data  (val_r),
    .wr_link_en   (wr_link_en),
    .wr_link_addr (wr_link_addr),
    .wr_link_data (wr_link_data),
    .rd_value     (rd_value),
    .rd_link      (rd_link)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    aux_nxt        = aux_r;
    nxt_nxt        = nxt_r;
    steps_nxt      = steps_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    rd_addr        = '0;
    wr_val_en      = 1'b0;
    wr_val_addr    = idx(free_r);
    wr_link_en     = 1'b0;
    wr_link_addr   = idx(cur_r);
    wr_link_data   = NIL;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_opcode;
          val_nxt    = in_value;
          key_nxt    = in_key;
          status_nxt = ST_OK;
          cur_nxt    = head_r;
          prev_nxt   = NIL;
          steps_nxt  = '0;
          state_nxt  = S_DONE;
          case (in_opcode)
            OP_PUSH_FRONT, OP_APPEND_TAIL: begin
              if (free_nil) begin
                status_nxt = ST_FULL;
              end else begin
                rd_addr   = idx(free_r);
                state_nxt = S_TAKE;
              end
            end
            OP_INSERT_AFT: begin
              if (free_nil) begin
                status_nxt = ST_FULL;
              end else if (head_nil) begin
                status_nxt = ST_NOKEY;
              end else begin
                rd_addr   = idx(head_r);
                state_nxt = S_WALK;
              end
            end
            OP_POP_FRONT: begin
              if (head_nil) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = idx(head_r);
                state_nxt = S_POP;
              end
            end
            OP_REMOVE_TAIL, OP_REMOVE_AFT: begin
              if (head_nil) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = idx(head_r);
                state_nxt = S_WALK;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      // read data is the free-list head node
      S_TAKE: begin
        wr_val_en    = 1'b1;
        wr_val_addr  = idx(free_r);
        wr_link_en   = 1'b1;
        wr_link_addr = idx(free_r);
        free_nxt     = rd_link_n;
        aux_nxt      = free_r;
        state_nxt    = S_DONE;
        case (op_r)
          OP_PUSH_FRONT: begin
            wr_link_data = head_nil ? NIL : head_r;
            head_nxt     = free_r;
          end
          OP_APPEND_TAIL: begin
            wr_link_data = NIL;
            if (head_nil) begin
              head_nxt = free_r;
            end else begin
              // new node is off the list, so reading the head here is safe
              rd_addr   = idx(head_r);
              cur_nxt   = head_r;
              steps_nxt = '0;
              state_nxt = S_WALK;
            end
          end
          default: begin
            // insert after key: cur_r holds the match, nxt_r its old link
            wr_link_data = nxt_r;
            state_nxt    = S_LINK;
          end
        endcase
      end

      // read data is the list head node
      S_POP: begin
        head_nxt     = rd_link_n;
        wr_link_en   = 1'b1;
        wr_link_addr = idx(head_r);
        wr_link_data = free_r;
        free_nxt     = head_r;
        state_nxt    = S_DONE;
      end

      // read data is node cur_r
      S_WALK: begin
        case (op_r)
          OP_APPEND_TAIL, OP_REMOVE_TAIL: begin
            if (walk_last) begin
              if (op_r == OP_APPEND_TAIL) begin
                wr_link_en   = 1'b1;
                wr_link_addr = idx(cur_r);
                wr_link_data = aux_r;
                state_nxt    = S_DONE;
              end else begin
                if (prev_r == NIL) begin
                  head_nxt = NIL;
                end else begin
                  wr_link_en   = 1'b1;
                  wr_link_addr = idx(prev_r);
                  wr_link_data = NIL;
                end
                aux_nxt   = cur_r;
                state_nxt = S_FREE;
              end
            end else begin
              prev_nxt  = cur_r;
              cur_nxt   = rd_link_n;
              steps_nxt = steps_r + LINK_W'(1);
              rd_addr   = idx(rd_link_n);
            end
          end
          default: begin
            if (key_hit) begin
              if (op_r == OP_INSERT_AFT) begin
                nxt_nxt   = rd_link_n;
                rd_addr   = idx(free_r);
                state_nxt = S_TAKE;
              end else if (rd_link_n == NIL) begin
                status_nxt = ST_NONEXT;
                state_nxt  = S_DONE;
              end else begin
                aux_nxt   = rd_link_n;
                rd_addr   = idx(rd_link_n);
                state_nxt = S_NEXT;
              end
            end else if (walk_last) begin
              status_nxt = ST_NOKEY;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt   = rd_link_n;
              steps_nxt = steps_r + LINK_W'(1);
              rd_addr   = idx(rd_link_n);
            end
          end
        endcase
      end

      // read data is the node after the match; unlink it
      S_NEXT: begin
        wr_link_en   = 1'b1;
        wr_link_addr = idx(cur_r);
        wr_link_data = rd_link_n;
        state_nxt    = S_FREE;
      end

      // return node aux_r to the free list head
      S_FREE: begin
        wr_link_en   = 1'b1;
        wr_link_addr = idx(aux_r);
        wr_link_data = free_r;
        free_nxt     = aux_r;
        state_nxt    = S_DONE;
      end

      S_LINK: begin
        wr_link_en   = 1'b1;
        wr_link_addr = idx(cur_r);
        wr_link_data = aux_r;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W - STATUS_W - 2){1'b0}}, free_nil, head_nil, status_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NIL;
      free_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_r       <= free_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    aux_r    <= aux_nxt;
    nxt_r    <= nxt_nxt;
    steps_r  <= steps_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/alle_store.sv
// ----------------------------------------------------------------------------
// alle_store
// Node store: value memory and link memory, one read port shared by both,
// registered read data. Link entries that were never written read as their
// reset chain value (next entry, null for the last).
// ----------------------------------------------------------------------------
`default_nettype none

module alle_store #(
  parameter  int NODE_COUNT = alle_pkg::NODE_COUNT_DEF,
  localparam int IDX_W      = $clog2(NODE_COUNT),
  localparam int LINK_W     = $clog2(NODE_COUNT + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [IDX_W-1:0]            rd_addr,
  input  wire logic                        wr_val_en,
  input  wire logic [IDX_W-1:0]            wr_val_addr,
  input  wire logic [alle_pkg::DATA_W-1:0] wr_val_data,
  input  wire logic                        wr_link_en,
  input  wire logic [IDX_W-1:0]            wr_link_addr,
  input  wire logic [LINK_W-1:0]           wr_link_data,
  output logic      [alle_pkg::DATA_W-1:0] rd_value,
  output logic      [LINK_W-1:0]           rd_link
);
  import alle_pkg::*;

  logic [DATA_W-1:0]     value_mem [NODE_COUNT];
  logic [LINK_W-1:0]     link_mem  [NODE_COUNT];
  logic [NODE_COUNT-1:0] link_vld_r;

  logic [DATA_W-1:0]     rd_value_r;
  logic [LINK_W-1:0]     rd_link_raw_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_vld_r;
  logic [LINK_W-1:0]     rd_link_dflt;

  always_ff @(posedge clk) begin
    if (wr_val_en) begin
      value_mem[wr_val_addr] <= wr_val_data;
    end
    rd_value_r <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_link_en) begin
      link_mem[wr_link_addr] <= wr_link_data;
    end
    rd_link_raw_r <= link_mem[rd_addr];
    rd_addr_r     <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (wr_link_en) begin
        link_vld_r[wr_link_addr] <= 1'b1;
      end
      rd_vld_r <= link_vld_r[rd_addr];
    end
  end

  // reset chain: entry i links i+1, last entry null
  assign rd_link_dflt = (rd_addr_r == IDX_W'(NODE_COUNT - 1)) ? LINK_W'(NODE_COUNT)
                                                              : LINK_W'(rd_addr_r) + LINK_W'(1);

  assign rd_value = rd_value_r;
  assign rd_link  = rd_vld_r ? rd_link_raw_r : rd_link_dflt;

endmodule

`default_nettype wire
